[rtl/tcps_pkg.sv]
// ----------------------------------------------------------------------------
// tcps_pkg
// Types and constants shared by the touch controller poll sequencer.
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned PhaseW   = 4;

  localparam logic [StatusW-1:0] CountMask = 8'h0F;
  localparam logic [StatusW-1:0] LargeBit  = 8'h40;

  // Register reset values
  localparam logic [CfgW-1:0]   ResetHoldRst   = 16'd30;
  localparam logic [CfgW-1:0]   SettleRst      = 16'd20;
  localparam logic [CfgW-1:0]   BusTimeoutRst  = 16'd100;
  localparam logic [CfgW-1:0]   PollGapRst     = 16'd20;
  localparam logic [CountW-1:0] MaxPointsRst   = 4'd5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgResetHold  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSettle     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBusTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPollGap    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxPoints  = 3'd4;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 2'd0,
    CMD_BUS_OK  = 2'd1,
    CMD_BUS_ERR = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [ReqW-1:0] {
    REQ_NONE     = 3'd0,
    REQ_READ_ID  = 3'd1,
    REQ_READ_CFG = 3'd2,
    REQ_READ_XY  = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef enum logic [PhaseW-1:0] {
    PH_PWR_ON     = 4'd0,
    PH_DRIVE_LOW  = 4'd1,
    PH_RESET_HOLD = 4'd2,
    PH_SETTLE     = 4'd3,
    PH_ID_CMD     = 4'd4,
    PH_ID_WAIT    = 4'd5,
    PH_CFG_CMD    = 4'd6,
    PH_CFG_WAIT   = 4'd7,
    PH_CLR_CMD    = 4'd8,
    PH_GAP        = 4'd9,
    PH_COORD_CMD  = 4'd10,
    PH_COORD_WAIT = 4'd11,
    PH_ERROR      = 4'd12
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0]   reset_hold;
    logic [CfgW-1:0]   settle;
    logic [CfgW-1:0]   bus_timeout;
    logic [CfgW-1:0]   poll_gap;
    logic [CountW-1:0] max_points;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic               bus_busy;
    logic [StatusW-1:0] last_status;
    logic [CountW-1:0]  valid_points;
    logic               reset_level;
    logic               int_released;
  } seq_state_t;

  typedef struct packed {
    req_e transfer_request;
    logic points_updated;
    logic restart;
  } step_flags_t;

endpackage

[rtl/tcps_if.sv]
// ----------------------------------------------------------------------------
// tcps_in_if / tcps_out_if
// Valid/ready channels carrying sequencer events and per-event results.
// ----------------------------------------------------------------------------
interface tcps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] read_status;

  modport source (output valid, output cmd, output read_status, input ready);
  modport sink   (input valid, input cmd, input read_status, output ready);
endinterface

interface tcps_out_if;
  logic       valid;
  logic       ready;
  logic       reset_pin;
  logic       int_floating;
  logic [2:0] transfer_request;
  logic [3:0] point_count;
  logic       points_updated;
  logic       restart;
  logic       in_error;
  logic [3:0] phase;

  modport source (output valid, output reset_pin, output int_floating,
                  output transfer_request, output point_count,
                  output points_updated, output restart, output in_error,
                  output phase, input ready);
  modport sink   (input valid, input reset_pin, input int_floating,
                  input transfer_request, input point_count,
                  input points_updated, input restart, input in_error,
                  input phase, output ready);
endinterface

[rtl/tcps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tcps_cfg_regs
// Timing and point-limit registers written through the configuration port.
// ----------------------------------------------------------------------------
module tcps_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [tcps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tcps_pkg::CfgW-1:0]    cfg_data_i,
  output tcps_pkg::cfg_t           cfg_o
);
  import tcps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgResetHold:  cfg_d.reset_hold  = cfg_data_i;
        CfgSettle:     cfg_d.settle      = cfg_data_i;
        CfgBusTimeout: cfg_d.bus_timeout = cfg_data_i;
        CfgPollGap:    cfg_d.poll_gap    = cfg_data_i;
        CfgMaxPoints:  cfg_d.max_points  = cfg_data_i[CountW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_hold  <= ResetHoldRst;
      cfg_q.settle      <= SettleRst;
      cfg_q.bus_timeout <= BusTimeoutRst;
      cfg_q.poll_gap    <= PollGapRst;
      cfg_q.max_points  <= MaxPointsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/tcps_step.sv]
// ----------------------------------------------------------------------------
// tcps_step
// Next-state logic of the sequencer for one event.
// ----------------------------------------------------------------------------
module tcps_step #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  tcps_pkg::seq_state_t    state_i,
  input  logic [TIMER_WIDTH-1:0]  elapsed_i,
  input  tcps_pkg::cfg_t          cfg_i,
  input  logic [tcps_pkg::CmdW-1:0]    cmd_i,
  input  logic [tcps_pkg::StatusW-1:0] status_i,
  output tcps_pkg::seq_state_t    state_o,
  output logic [TIMER_WIDTH-1:0]  elapsed_o,
  output tcps_pkg::step_flags_t   flags_o
);
  import tcps_pkg::*;

  localparam int unsigned CmpW = (TIMER_WIDTH > CfgW) ? TIMER_WIDTH : CfgW;

  logic [TIMER_WIDTH-1:0] el_inc;
  logic [CmpW-1:0]        el_ext;
  logic                   ge_hold, ge_settle, ge_timeout, ge_gap;
  logic                   bus_free, timeout_hit;
  logic [CountW-1:0]      n_pts;
  logic                   n_ok;

  // Saturating tick count
  assign el_inc = (&elapsed_i) ? elapsed_i : elapsed_i + 1'b1;
  assign el_ext = CmpW'(el_inc);

  assign ge_hold    = el_ext >= CmpW'(cfg_i.reset_hold);
  assign ge_settle  = el_ext >= CmpW'(cfg_i.settle);
  assign ge_timeout = el_ext >= CmpW'(cfg_i.bus_timeout);
  assign ge_gap     = el_ext >= CmpW'(cfg_i.poll_gap);

  assign bus_free    = !state_i.bus_busy;
  assign timeout_hit = state_i.bus_busy && ge_timeout;

  assign n_pts = state_i.last_status[CountW-1:0] & CountMask[CountW-1:0];
  assign n_ok  = (n_pts != '0) && (n_pts <= cfg_i.max_points);

  always_comb begin
    state_o   = state_i;
    elapsed_o = elapsed_i;
    flags_o   = '{transfer_request: REQ_NONE, points_updated: 1'b0, restart: 1'b0};

    case (cmd_e'(cmd_i))
      CMD_BUS_OK: begin
        if (state_i.bus_busy && state_i.phase == PH_COORD_WAIT) begin
          state_o.last_status = status_i;
        end
        state_o.bus_busy = 1'b0;
      end
      CMD_TICK: begin
        elapsed_o = el_inc;
        // Phases that wait on the bus share the timeout restart
        if (!bus_free && timeout_hit &&
            (state_i.phase == PH_ID_CMD  || state_i.phase == PH_ID_WAIT  ||
             state_i.phase == PH_CFG_CMD || state_i.phase == PH_CFG_WAIT ||
             state_i.phase == PH_CLR_CMD || state_i.phase == PH_COORD_CMD ||
             state_i.phase == PH_COORD_WAIT)) begin
          state_o.phase   = PH_PWR_ON;
          elapsed_o       = '0;
          flags_o.restart = 1'b1;
        end else begin
          case (state_i.phase)
            PH_PWR_ON: state_o.phase = PH_DRIVE_LOW;
            PH_DRIVE_LOW: begin
              state_o.int_released = 1'b0;
              state_o.reset_level  = 1'b0;
              state_o.phase        = PH_RESET_HOLD;
              elapsed_o            = '0;
            end
            PH_RESET_HOLD: begin
              if (ge_hold) begin
                state_o.reset_level = 1'b1;
                state_o.phase       = PH_SETTLE;
                elapsed_o           = '0;
              end
            end
            PH_SETTLE: begin
              if (ge_settle) begin
                state_o.int_released = 1'b1;
                state_o.phase        = PH_ID_CMD;
                elapsed_o            = '0;
              end
            end
            PH_ID_CMD: begin
              if (bus_free) begin
                state_o.bus_busy         = 1'b1;
                flags_o.transfer_request = REQ_READ_ID;
                state_o.phase            = PH_ID_WAIT;
                elapsed_o                = '0;
              end
            end
            PH_ID_WAIT: begin
              if (bus_free) begin
                state_o.phase = PH_CFG_CMD;
                elapsed_o     = '0;
              end
            end
            PH_CFG_CMD: begin
              if (bus_free) begin
                state_o.bus_busy         = 1'b1;
                flags_o.transfer_request = REQ_READ_CFG;
                state_o.phase            = PH_CFG_WAIT;
                elapsed_o                = '0;
              end
            end
            PH_CFG_WAIT: begin
              if (bus_free) begin
                state_o.phase = PH_CLR_CMD;
                elapsed_o     = '0;
              end
            end
            PH_CLR_CMD: begin
              if (bus_free) begin
                state_o.bus_busy         = 1'b1;
                flags_o.transfer_request = REQ_CLEAR;
                state_o.phase            = PH_GAP;
                elapsed_o                = '0;
              end
            end
            PH_GAP: begin
              if (ge_gap) begin
                state_o.phase = PH_COORD_CMD;
                elapsed_o     = '0;
              end
            end
            PH_COORD_CMD: begin
              if (bus_free) begin
                state_o.bus_busy         = 1'b1;
                flags_o.transfer_request = REQ_READ_XY;
                state_o.phase            = PH_COORD_WAIT;
                elapsed_o                = '0;
              end
            end
            PH_COORD_WAIT: begin
              if (bus_free) begin
                state_o.valid_points   = n_ok ? n_pts : '0;
                flags_o.points_updated = 1'b1;
                // Large touch is terminal; the timer keeps running there
                if ((state_i.last_status & LargeBit) != '0) begin
                  state_o.phase = PH_ERROR;
                end else begin
                  state_o.phase = PH_CLR_CMD;
                  elapsed_o     = '0;
                end
              end
            end
            default: state_o.phase = state_i.phase;
          endcase
        end
      end
      default: state_o = state_i;
    endcase
  end

endmodule

[rtl/touch_controller_poll_sequencer.sv]
// ----------------------------------------------------------------------------
// touch_controller_poll_sequencer
// Power-on and coordinate polling sequencer for a capacitive touch controller.
// ----------------------------------------------------------------------------
// Usage:
//   evt   : sink channel of events - a 1 ms tick, a bus transfer done or a
//           bus transfer failed, plus the status byte of a coordinate read.
//   res   : source channel with one result per event: pin levels, the
//           transfer to start, the point count and the current phase.
//   cfg   : write-only register port (hold, settle, timeout, poll gap, max
//           points), written while no event is in flight.
// Each event is taken into the sequencer state and its result is registered
// in the same cycle, so a result is offered in the cycle after the event
// transaction. One event per cycle is sustained while results are taken;
// the state registers and the timer compare/increment form the only loop.
// The event channel stays ready while the result register is empty or is
// being drained in the same cycle; a stalled receiver holds the result and
// back-pressures the event side after one transaction.
// Reset puts the sequencer in the power-on phase with reset and the interrupt
// line driven low and restores the register defaults.
// ----------------------------------------------------------------------------
module touch_controller_poll_sequencer #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcps_pkg::CfgW-1:0]     cfg_data_i,
  tcps_in_if.sink                       evt,
  tcps_out_if.source                    res
);
  import tcps_pkg::*;

  cfg_t                   cfg;
  seq_state_t             state_q, state_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  step_flags_t            flags_d, flags_q;
  logic                   res_valid_q;
  logic                   evt_fire;

  tcps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  tcps_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .state_i  (state_q),
    .elapsed_i(elapsed_q),
    .cfg_i    (cfg),
    .cmd_i    (evt.cmd),
    .status_i (evt.read_status),
    .state_o  (state_d),
    .elapsed_o(elapsed_d),
    .flags_o  (flags_d)
  );

  assign evt.ready = !res_valid_q || res.ready;
  assign evt_fire  = evt.valid && evt.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_PWR_ON, bus_busy: 1'b0, last_status: '0,
                       valid_points: '0, reset_level: 1'b0, int_released: 1'b0};
      elapsed_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (evt_fire) begin
        state_q   <= state_d;
        elapsed_q <= elapsed_d;
      end
      if (evt_fire) begin
        res_valid_q <= 1'b1;
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Per-event flags sit beside the state, which already holds the rest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '{transfer_request: REQ_NONE, points_updated: 1'b0, restart: 1'b0};
    end else if (evt_fire) begin
      flags_q <= flags_d;
    end
  end

  assign res.valid            = res_valid_q;
  assign res.reset_pin        = state_q.reset_level;
  assign res.int_floating     = state_q.int_released;
  assign res.transfer_request = flags_q.transfer_request;
  assign res.point_count      = state_q.valid_points;
  assign res.points_updated   = flags_q.points_updated;
  assign res.restart          = flags_q.restart;
  assign res.in_error         = (state_q.phase == PH_ERROR);
  assign res.phase            = state_q.phase;

endmodule

[tb/touch_controller_poll_sequencer_test.sv]
// ----------------------------------------------------------------------------
// touch_controller_poll_sequencer_test
// Self-checking bench for the touch controller poll sequencer. A short table
// of directed events walks the block through power-on, the identity and config
// reads, one poll loop and a bus timeout. Random events then follow under a
// series of register settings, extremes included. Every result transaction is
// compared field by field against its table entry or the sequencer model.
// ----------------------------------------------------------------------------
module touch_controller_poll_sequencer_test;
  import tcps_pkg::*;

  localparam int unsigned TimerW      = 16;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned NumDirected = 25;

  typedef struct packed {
    logic               reset_pin;
    logic               int_floating;
    req_e               req;
    logic [CountW-1:0]  points;
    logic               upd;
    logic               restart;
    logic               in_error;
    logic [PhaseW-1:0]  phase;
  } seq_result_t;

  typedef struct {
    cmd_e               cmd;
    logic [StatusW-1:0] status;
    int unsigned        reps;
    bit                 typed;
    seq_result_t        want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  tcps_in_if  evt_ch ();
  tcps_out_if res_ch ();

  touch_controller_poll_sequencer #(
    .TIMER_WIDTH (TimerW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt        (evt_ch),
    .res        (res_ch)
  );

  // Model copy of the registers and the sequencer state
  logic [CfgW-1:0]    hold_ticks;
  logic [CfgW-1:0]    settle_ticks;
  logic [CfgW-1:0]    timeout_ticks;
  logic [CfgW-1:0]    gap_ticks;
  logic [CountW-1:0]  max_pts;
  phase_e             seq_phase;
  logic [TimerW-1:0]  seq_elapsed;
  logic               seq_busy;
  logic [StatusW-1:0] seq_status;
  logic [CountW-1:0]  seq_points;
  logic               seq_rst_level;
  logic               seq_int_rel;

  seq_result_t pending_results [$];
  stim_row_t   directed_rows [NumDirected];

  int unsigned fail_cnt      = 0;
  int unsigned events_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned restarts_seen = 0;
  int unsigned updates_seen  = 0;
  int unsigned cfg_rounds    = 0;
  int unsigned cycle_cnt     = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void enter_phase(phase_e p);
    seq_phase   = p;
    seq_elapsed = '0;
  endfunction

  // Advances the model by one event and returns the result it should produce
  function automatic seq_result_t sequencer_step(cmd_e cmd, logic [StatusW-1:0] status);
    seq_result_t        r;
    logic [StatusW-1:0] n;
    r = '0;
    if (cmd == CMD_BUS_OK) begin
      // status only latched for a pending coordinate read
      if (seq_busy && seq_phase == PH_COORD_WAIT) seq_status = status;
      seq_busy = 1'b0;
    end else if (cmd == CMD_TICK) begin
      if (seq_elapsed != '1) seq_elapsed = seq_elapsed + 1'b1;
      case (seq_phase)
        PH_PWR_ON: seq_phase = PH_DRIVE_LOW;
        PH_DRIVE_LOW: begin
          seq_int_rel   = 1'b0;
          seq_rst_level = 1'b0;
          enter_phase(PH_RESET_HOLD);
        end
        PH_RESET_HOLD: if (seq_elapsed >= hold_ticks) begin
          seq_rst_level = 1'b1;
          enter_phase(PH_SETTLE);
        end
        PH_SETTLE: if (seq_elapsed >= settle_ticks) begin
          seq_int_rel = 1'b1;
          enter_phase(PH_ID_CMD);
        end
        PH_GAP: if (seq_elapsed >= gap_ticks) enter_phase(PH_COORD_CMD);
        PH_ERROR: ;
        default: begin
          // bus phases: a free bus always proceeds, a busy one may time out
          if (seq_busy) begin
            if (seq_elapsed >= timeout_ticks) begin
              enter_phase(PH_PWR_ON);
              r.restart = 1'b1;
            end
          end else begin
            case (seq_phase)
              PH_ID_CMD: begin
                seq_busy = 1'b1;
                r.req    = REQ_READ_ID;
                enter_phase(PH_ID_WAIT);
              end
              PH_ID_WAIT: enter_phase(PH_CFG_CMD);
              PH_CFG_CMD: begin
                seq_busy = 1'b1;
                r.req    = REQ_READ_CFG;
                enter_phase(PH_CFG_WAIT);
              end
              PH_CFG_WAIT: enter_phase(PH_CLR_CMD);
              PH_CLR_CMD: begin
                seq_busy = 1'b1;
                r.req    = REQ_CLEAR;
                enter_phase(PH_GAP);
              end
              PH_COORD_CMD: begin
                seq_busy = 1'b1;
                r.req    = REQ_READ_XY;
                enter_phase(PH_COORD_WAIT);
              end
              default: begin
                n          = seq_status & CountMask;
                seq_points = (n >= 1 && n <= max_pts) ? n[CountW-1:0] : '0;
                r.upd      = 1'b1;
                // large touch: terminal, timer left running
                if ((seq_status & LargeBit) != '0) seq_phase = PH_ERROR;
                else enter_phase(PH_CLR_CMD);
              end
            endcase
          end
        end
      endcase
    end
    r.reset_pin    = seq_rst_level;
    r.int_floating = seq_int_rel;
    r.points       = seq_points;
    r.in_error     = (seq_phase == PH_ERROR);
    r.phase        = seq_phase;
    return r;
  endfunction

  function automatic stim_row_t pred_row(cmd_e c, logic [StatusW-1:0] st, int unsigned reps);
    stim_row_t row;
    row.cmd    = c;
    row.status = st;
    row.reps   = reps;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(cmd_e c, logic [StatusW-1:0] st, int unsigned rp,
                                          int unsigned intf, req_e rq, int unsigned pts,
                                          int unsigned upd, int unsigned rs, phase_e ph);
    stim_row_t row;
    row.cmd                 = c;
    row.status              = st;
    row.reps                = 1;
    row.typed               = 1'b1;
    row.want.reset_pin      = 1'(rp);
    row.want.int_floating   = 1'(intf);
    row.want.req            = rq;
    row.want.points         = CountW'(pts);
    row.want.upd            = 1'(upd);
    row.want.restart        = 1'(rs);
    row.want.in_error       = (ph == PH_ERROR);
    row.want.phase          = ph;
    return row;
  endfunction

  // Drives one event, waits for its transaction and queues the expected result
  task automatic send_event(input cmd_e c, input logic [StatusW-1:0] st, input bit typed,
                            input seq_result_t typed_res);
    seq_result_t got;
    evt_ch.valid       <= 1'b1;
    evt_ch.cmd         <= c;
    evt_ch.read_status <= st;
    @(posedge clk_i);
    while (!evt_ch.ready) @(posedge clk_i);
    got = sequencer_step(c, st);
    restarts_seen += got.restart;
    updates_seen  += got.upd;
    events_sent++;
    pending_results.push_back(typed ? typed_res : got);
    if (!tx_quiet && $urandom_range(0, 7) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    evt_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all five registers plus one unused index, block idle
  task automatic program_regs(input logic [CfgW-1:0] hold, input logic [CfgW-1:0] settle,
                              input logic [CfgW-1:0] tmo, input logic [CfgW-1:0] gap,
                              input logic [CfgW-1:0] maxp);
    logic [CfgIdxW-1:0] idx_list [6];
    logic [CfgW-1:0]    val_list [6];
    idx_list[0] = CfgResetHold;  val_list[0] = hold;
    idx_list[1] = CfgSettle;     val_list[1] = settle;
    idx_list[2] = CfgBusTimeout; val_list[2] = tmo;
    idx_list[3] = CfgPollGap;    val_list[3] = gap;
    idx_list[4] = CfgMaxPoints;  val_list[4] = maxp;
    idx_list[5] = CfgMaxPoints + CfgIdxW'($urandom_range(1, 3));
    val_list[5] = CfgW'($urandom);
    drain_results();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
      @(posedge clk_i);
      case (idx_list[i])
        CfgResetHold:  hold_ticks    = val_list[i];
        CfgSettle:     settle_ticks  = val_list[i];
        CfgBusTimeout: timeout_ticks = val_list[i];
        CfgPollGap:    gap_ticks     = val_list[i];
        CfgMaxPoints:  max_pts       = val_list[i][CountW-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    cfg_rounds++;
  endtask

  // Mostly the traffic a real bus would give, with failures and stray events
  task automatic run_random(input int unsigned n_items, input int unsigned ok_pct,
                            input bit allow_large);
    cmd_e               c;
    logic [StatusW-1:0] st;
    int unsigned        roll;
    bit                 on_bus;
    seq_result_t        none_res;
    none_res = '0;
    for (int unsigned k = 0; k < n_items; k++) begin
      on_bus = (seq_phase >= PH_ID_CMD && seq_phase <= PH_CLR_CMD) ||
               seq_phase == PH_COORD_CMD || seq_phase == PH_COORD_WAIT;
      roll = $urandom_range(0, 99);
      if (on_bus && seq_busy) begin
        if (roll < ok_pct)  c = CMD_BUS_OK;
        else if (roll < 92) c = CMD_TICK;
        else if (roll < 97) c = CMD_BUS_ERR;
        else                c = CMD_NONE;
      end else begin
        if (roll < 84)      c = CMD_TICK;
        else if (roll < 92) c = CMD_BUS_OK;
        else if (roll < 97) c = CMD_BUS_ERR;
        else                c = CMD_NONE;
      end
      st = StatusW'($urandom_range(0, 255));
      if (c == CMD_BUS_OK && seq_busy && seq_phase == PH_COORD_WAIT) begin
        if ($urandom_range(0, 3) != 0)
          st[3:0] = CountW'(1 + $urandom_range(0, (max_pts > 1) ? max_pts - 1 : 0));
        // large touch is terminal, so it is kept for the closing stretch
        if (!allow_large) st[6] = 1'b0;
      end
      if (!tx_quiet && $urandom_range(0, 249) == 0) drain_results();
      send_event(c, st, 1'b0, none_res);
    end
  endtask

  // Receiver: random stall bursts until the closing stretch
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rx_quiet && $urandom_range(0, 11) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    seq_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected, phase %0d", res_ch.phase);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (want.reset_pin !== res_ch.reset_pin) begin
          $error("reset_pin: expected %0d, got %0d", want.reset_pin, res_ch.reset_pin);
          fail_cnt++;
        end
        if (want.int_floating !== res_ch.int_floating) begin
          $error("int_floating: expected %0d, got %0d", want.int_floating, res_ch.int_floating);
          fail_cnt++;
        end
        if (want.req !== res_ch.transfer_request) begin
          $error("transfer_request: expected %0d, got %0d", want.req, res_ch.transfer_request);
          fail_cnt++;
        end
        if (want.points !== res_ch.point_count) begin
          $error("point_count: expected %0d, got %0d", want.points, res_ch.point_count);
          fail_cnt++;
        end
        if (want.upd !== res_ch.points_updated) begin
          $error("points_updated: expected %0d, got %0d", want.upd, res_ch.points_updated);
          fail_cnt++;
        end
        if (want.restart !== res_ch.restart) begin
          $error("restart: expected %0d, got %0d", want.restart, res_ch.restart);
          fail_cnt++;
        end
        if (want.in_error !== res_ch.in_error) begin
          $error("in_error: expected %0d, got %0d", want.in_error, res_ch.in_error);
          fail_cnt++;
        end
        if (want.phase !== res_ch.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, res_ch.phase);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("touch_controller_poll_sequencer_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgResetHold;
    cfg_data_i         <= '0;
    evt_ch.valid       <= 1'b0;
    evt_ch.cmd         <= CMD_TICK;
    evt_ch.read_status <= '0;

    hold_ticks    = ResetHoldRst;
    settle_ticks  = SettleRst;
    timeout_ticks = BusTimeoutRst;
    gap_ticks     = PollGapRst;
    max_pts       = MaxPointsRst;
    seq_phase     = PH_PWR_ON;
    seq_elapsed   = '0;
    seq_busy      = 1'b0;
    seq_status    = '0;
    seq_points    = '0;
    seq_rst_level = 1'b0;
    seq_int_rel   = 1'b0;

    // reset defaults: hold 30, settle 20, gap 20, timeout 100, max 5
    directed_rows[0]  = typed_row(CMD_TICK, 8'h00, 0, 0, REQ_NONE, 0, 0, 0, PH_DRIVE_LOW);
    directed_rows[1]  = typed_row(CMD_TICK, 8'h00, 0, 0, REQ_NONE, 0, 0, 0, PH_RESET_HOLD);
    directed_rows[2]  = typed_row(CMD_NONE, 8'hFF, 0, 0, REQ_NONE, 0, 0, 0, PH_RESET_HOLD);
    directed_rows[3]  = typed_row(CMD_BUS_ERR, 8'h00, 0, 0, REQ_NONE, 0, 0, 0, PH_RESET_HOLD);
    // done with no transfer pending: status dropped
    directed_rows[4]  = typed_row(CMD_BUS_OK, 8'hFF, 0, 0, REQ_NONE, 0, 0, 0, PH_RESET_HOLD);
    directed_rows[5]  = pred_row(CMD_TICK, 8'h00, 29);
    directed_rows[6]  = typed_row(CMD_TICK, 8'h00, 1, 0, REQ_NONE, 0, 0, 0, PH_SETTLE);
    directed_rows[7]  = pred_row(CMD_TICK, 8'h00, 19);
    directed_rows[8]  = typed_row(CMD_TICK, 8'h00, 1, 1, REQ_NONE, 0, 0, 0, PH_ID_CMD);
    directed_rows[9]  = typed_row(CMD_TICK, 8'h00, 1, 1, REQ_READ_ID, 0, 0, 0, PH_ID_WAIT);
    directed_rows[10] = pred_row(CMD_BUS_OK, 8'hAA, 1);
    directed_rows[11] = pred_row(CMD_TICK, 8'h00, 1);
    directed_rows[12] = pred_row(CMD_TICK, 8'h00, 1);
    directed_rows[13] = pred_row(CMD_BUS_OK, 8'h55, 1);
    directed_rows[14] = pred_row(CMD_TICK, 8'h00, 1);
    directed_rows[15] = pred_row(CMD_TICK, 8'h00, 1);
    directed_rows[16] = pred_row(CMD_BUS_OK, 8'h3C, 1);
    directed_rows[17] = pred_row(CMD_TICK, 8'h00, 20);
    directed_rows[18] = pred_row(CMD_TICK, 8'h00, 1);
    directed_rows[19] = pred_row(CMD_BUS_OK, 8'h0F, 1);
    // count of 15 is above max points: reported as none
    directed_rows[20] = typed_row(CMD_TICK, 8'h00, 1, 1, REQ_NONE, 0, 1, 0, PH_CLR_CMD);
    directed_rows[21] = pred_row(CMD_TICK, 8'h00, 1);
    // clear never completes: coordinate command times out
    directed_rows[22] = pred_row(CMD_TICK, 8'h00, 20);
    directed_rows[23] = pred_row(CMD_TICK, 8'h00, 99);
    directed_rows[24] = typed_row(CMD_TICK, 8'h00, 1, 1, REQ_NONE, 0, 0, 1, PH_PWR_ON);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      for (int unsigned j = 0; j < directed_rows[r].reps; j++)
        send_event(directed_rows[r].cmd, directed_rows[r].status, directed_rows[r].typed,
                   directed_rows[r].want);

    run_random(150, 55, 1'b0);
    program_regs(16'd1, 16'd1, 16'd4, 16'd1, 16'd10);
    run_random(250, 55, 1'b0);
    // zero waits and a max of zero: every count rejected
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFF0);
    run_random(150, 55, 1'b0);
    program_regs(16'd3, 16'd2, 16'd12, 16'd3, 16'd1);
    run_random(250, 30, 1'b0);
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60, 55, 1'b0);
    for (int p = 0; p < 4; p++) begin
      program_regs(CfgW'($urandom_range(1, 5)), CfgW'($urandom_range(1, 5)),
                   CfgW'($urandom_range(2, 20)), CfgW'($urandom_range(1, 6)),
                   CfgW'(($urandom_range(0, 4095) << 4) | $urandom_range(1, 10)));
      run_random(200, (p % 2 == 1) ? 25 : 60, 1'b0);
    end

    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    program_regs(CfgW'($urandom_range(1, 3)), CfgW'($urandom_range(1, 3)),
                 CfgW'($urandom_range(4, 20)), CfgW'($urandom_range(1, 3)),
                 CfgW'($urandom_range(1, 10)));
    run_random(100, 60, 1'b1);
    drain_results();

    $display("covered %0d events under %0d register settings, %0d results checked",
             events_sent, cfg_rounds + 1, results_seen);
    $display("bus timeout restarts %0d, coordinate status evaluations %0d, ended in error %0d",
             restarts_seen, updates_seen, seq_phase == PH_ERROR);
    if (fail_cnt == 0) begin
      $display("touch_controller_poll_sequencer_test: done, clean");
    end else begin
      $display("touch_controller_poll_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule
